// ===== src/rclt_pkg.sv =====
package rclt_pkg;

  // Default sizes of the slot table
  localparam int NUM_SLOTS_DEF = 16;
  localparam int KEY_BITS_DEF  = 32;
  localparam int REF_BITS_DEF  = 8;

  // Request operation codes
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_ACQ_EXISTING = 3'd0;
  localparam logic [2:0] ST_ACQ_NEW      = 3'd1;
  localparam logic [2:0] ST_FULL         = 3'd2;
  localparam logic [2:0] ST_OVERFLOW     = 3'd3;
  localparam logic [2:0] ST_RELEASED     = 3'd4;
  localparam logic [2:0] ST_FREED        = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd6;

  typedef struct packed {
    logic        operation;
    logic [31:0] resource_key;
  } rclt_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_index;
    logic [7:0] holder_count;
    logic [4:0] active_entries;
  } rclt_rsp_t;

endpackage

// ===== src/rclt_front.sv =====
module rclt_front #(
  parameter int KEY_BITS = rclt_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rclt_pkg::rclt_req_t req,
  output logic                cmd_push,
  output logic [KEY_BITS:0]   cmd_data,
  input  logic                cmd_ready
);

  logic              fr_valid;
  logic [KEY_BITS:0] fr_cmd;
  logic [63:0]       key_wide;

  // Key is the low KEY_BITS of the request key, zero-extended when wider
  assign key_wide = {32'b0, req.resource_key};

  assign req_stall = fr_valid && !cmd_ready;
  assign cmd_push  = fr_valid && cmd_ready;
  assign cmd_data  = fr_cmd;

  // Single holding stage in front of the command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      fr_valid <= 1'b1;
    end else if (cmd_push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      fr_cmd <= {req.operation, key_wide[KEY_BITS-1:0]};
    end
  end

endmodule

// ===== src/rclt_queue.sv =====
module rclt_queue #(
  parameter int WIDTH = rclt_pkg::KEY_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  output logic             valid,
  output logic [WIDTH-1:0] data,
  input  logic             pop
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] entries [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign ready = (count != 2'(DEPTH));
  assign valid = (count != 2'd0);
  assign data  = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/rclt_back.sv =====
module rclt_back #(
  parameter int NUM_SLOTS = rclt_pkg::NUM_SLOTS_DEF,
  parameter int KEY_BITS  = rclt_pkg::KEY_BITS_DEF,
  parameter int REF_BITS  = rclt_pkg::REF_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic [KEY_BITS:0]   cmd_data,
  output logic                cmd_pop,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rclt_pkg::rclt_rsp_t rsp
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int LIVE_W = $clog2(NUM_SLOTS + 1);
  localparam logic [REF_BITS-1:0] REF_MAX  = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_ONE  = REF_BITS'(1);
  localparam logic [SLOT_W-1:0]   LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0]          state;
  logic                cmd_op;
  logic [KEY_BITS-1:0] cmd_key;
  logic [SLOT_W-1:0]   scan_idx;
  logic                cmp_en;
  logic [SLOT_W-1:0]   cmp_idx;
  logic [KEY_BITS-1:0] key_rd;
  logic [REF_BITS-1:0] ref_rd;
  logic                hit_found;
  logic [SLOT_W-1:0]   hit_idx;
  logic [REF_BITS-1:0] hit_refs;
  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [LIVE_W-1:0]   live_count;

  logic [KEY_BITS-1:0] key_mem [NUM_SLOTS];
  logic [REF_BITS-1:0] ref_mem [NUM_SLOTS];

  // Update decision
  logic [2:0]          status_next;
  logic [SLOT_W-1:0]   slot_next;
  logic [REF_BITS-1:0] refs_next;
  logic                wr_key_en;
  logic                wr_ref_en;
  logic                set_valid;
  logic                clr_valid;
  logic [LIVE_W-1:0]   live_next;
  logic                out_load;
  logic [SLOT_W+3:0]   slot_ext;
  logic [REF_BITS+7:0] refs_ext;
  logic [LIVE_W+4:0]   live_ext;

  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign out_load = (state == S_UPDATE) && (!rsp_valid || !rsp_stall);

  // Outcome of the command from the scan results
  always_comb begin
    status_next = rclt_pkg::ST_FULL;
    slot_next   = '0;
    refs_next   = '0;
    wr_key_en   = 1'b0;
    wr_ref_en   = 1'b0;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    live_next   = live_count;
    if (cmd_op == rclt_pkg::OP_ACQUIRE) begin
      if (hit_found) begin
        slot_next = hit_idx;
        if (hit_refs == REF_MAX) begin
          status_next = rclt_pkg::ST_OVERFLOW;
          refs_next   = hit_refs;
        end else begin
          status_next = rclt_pkg::ST_ACQ_EXISTING;
          refs_next   = hit_refs + REF_ONE;
          wr_ref_en   = 1'b1;
        end
      end else if (free_found) begin
        status_next = rclt_pkg::ST_ACQ_NEW;
        slot_next   = free_idx;
        refs_next   = REF_ONE;
        wr_key_en   = 1'b1;
        wr_ref_en   = 1'b1;
        set_valid   = 1'b1;
        live_next   = live_count + LIVE_W'(1);
      end
    end else begin
      if (!hit_found) begin
        status_next = rclt_pkg::ST_NOT_FOUND;
      end else if (hit_refs <= REF_ONE) begin
        status_next = rclt_pkg::ST_FREED;
        slot_next   = hit_idx;
        wr_ref_en   = 1'b1;
        clr_valid   = 1'b1;
        if (live_count != '0) begin
          live_next = live_count - LIVE_W'(1);
        end
      end else begin
        status_next = rclt_pkg::ST_RELEASED;
        slot_next   = hit_idx;
        refs_next   = hit_refs - REF_ONE;
        wr_ref_en   = 1'b1;
      end
    end
  end

  // Result fields are the low bits of slot, count and live total
  assign slot_ext = {4'b0, slot_next};
  assign refs_ext = {8'b0, refs_next};
  assign live_ext = {5'b0, live_next};

  // Sequencer: take a command, scan all slots, then update
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cmp_en <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_en <= 1'b1;
          if (scan_idx == LAST_IDX) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          cmp_en <= 1'b0;
          state  <= S_UPDATE;
        end
        S_UPDATE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command latch, scan index and match tracking
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_op     <= cmd_data[KEY_BITS];
      cmd_key    <= cmd_data[KEY_BITS-1:0];
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (state == S_SCAN) begin
        scan_idx <= scan_idx + SLOT_W'(1);
      end
      if (cmp_en) begin
        if (slot_valid[cmp_idx]) begin
          if (!hit_found && key_rd == cmd_key) begin
            hit_found <= 1'b1;
            hit_idx   <= cmp_idx;
            hit_refs  <= ref_rd;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
    end
  end

  // Key and count memories: one read port for the scan, one write port
  always_ff @(posedge clk) begin
    key_rd  <= key_mem[scan_idx];
    ref_rd  <= ref_mem[scan_idx];
    cmp_idx <= scan_idx;
    if (out_load && wr_key_en) begin
      key_mem[slot_next] <= cmd_key;
    end
    if (out_load && wr_ref_en) begin
      ref_mem[slot_next] <= refs_next;
    end
  end

  // Valid bits and live total
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      live_count <= '0;
    end else if (out_load) begin
      if (set_valid) begin
        slot_valid[slot_next] <= 1'b1;
      end
      if (clr_valid) begin
        slot_valid[slot_next] <= 1'b0;
      end
      live_count <= live_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status         <= status_next;
      rsp.slot_index     <= slot_ext[3:0];
      rsp.holder_count   <= refs_ext[7:0];
      rsp.active_entries <= live_ext[4:0];
    end
  end

`ifndef ASSERT_OFF
  a_live_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == int'(live_count))
    else $error("live total differs from number of valid slots");

  a_new_grows: assert property (@(posedge clk) disable iff (rst)
    out_load && status_next == rclt_pkg::ST_ACQ_NEW
      |=> live_count == $past(live_count) + LIVE_W'(1))
    else $error("new entry did not raise live total");

  a_freed_shrinks: assert property (@(posedge clk) disable iff (rst)
    out_load && status_next == rclt_pkg::ST_FREED
      |=> live_count == $past(live_count) - LIVE_W'(1))
    else $error("freed entry did not lower live total");

  a_pop_starts_scan: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> state == S_SCAN && scan_idx == '0 && !hit_found && !free_found)
    else $error("scan did not start cleanly");
`endif

endmodule

// ===== src/refcounted_lock_table.sv =====
// Channel | Handshake            | Payload | Direction
// req     | req_valid, req_stall | req     | in  (operation, resource_key)
// rsp     | rsp_valid, rsp_stall | rsp     | out (status, slot, count, live)
//
// Each request passes through the back end in order: it is taken from the
// queue, every slot is scanned through the key and count memories, a drain
// step covers the last registered read, and the update writes the result.
// The front stage and a two-entry queue take further requests during a scan.
// Reset (rst, synchronous) clears all valid bits and the live total at once.
// A stalled result holds the update until the output register frees.
module refcounted_lock_table #(
  parameter int NUM_SLOTS = rclt_pkg::NUM_SLOTS_DEF,
  parameter int KEY_BITS  = rclt_pkg::KEY_BITS_DEF,
  parameter int REF_BITS  = rclt_pkg::REF_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rclt_pkg::rclt_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rclt_pkg::rclt_rsp_t rsp
);

  logic              cmd_push;
  logic [KEY_BITS:0] cmd_in;
  logic              cmd_ready;
  logic              cmd_valid;
  logic [KEY_BITS:0] cmd_out;
  logic              cmd_pop;

  rclt_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in),
    .cmd_ready (cmd_ready)
  );

  rclt_queue #(
    .WIDTH (KEY_BITS + 1)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .ready     (cmd_ready),
    .valid     (cmd_valid),
    .data      (cmd_out),
    .pop       (cmd_pop)
  );

  rclt_back #(
    .NUM_SLOTS (NUM_SLOTS),
    .KEY_BITS  (KEY_BITS),
    .REF_BITS  (REF_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
